@@ rtl/core/bcm_pkg.sv @@
// shared types and constants of the battery cutoff monitor
`default_nettype none
package bcm_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EMA_V,
		ST_EMA_A,
		ST_FILT_V,
		ST_FILT_A,
		ST_RAW_V,
		ST_RAW_A,
		ST_FINISH
	} seq_state_t;

	// configuration register indexes
	localparam logic [2:0] REG_SMOOTHING_K  = 3'd0;
	localparam logic [2:0] REG_VOLT_SCALE   = 3'd1;
	localparam logic [2:0] REG_AMP_SCALE    = 3'd2;
	localparam logic [2:0] REG_LOW_CUTOFF   = 3'd3;
	localparam logic [2:0] REG_HIGH_CUTOFF  = 3'd4;
	localparam logic [2:0] REG_CURR_FLOOR   = 3'd5;
	localparam logic [2:0] REG_HOLD_SECONDS = 3'd6;
	localparam logic [2:0] REG_START_MODE   = 3'd7;

	// run modes
	localparam logic [1:0] MODE_IDLE      = 2'd0;
	localparam logic [1:0] MODE_DISCHARGE = 2'd1;
	localparam logic [1:0] MODE_CHARGE    = 2'd2;
	localparam logic [1:0] MODE_INVALID   = 2'd3;

	// input command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_START  = 1'b1;

	// register widths and result word layout
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 20;
	localparam int SCALE_W     = 20;
	localparam int WEIGHT_W    = 16;
	localparam int MEAS_W      = 16;
	localparam int OUT_DATA_W  = 72;
	localparam int ROUND_SHIFT = 16;

	localparam logic [MEAS_W-1:0] MEAS_MAX = 16'hFFFF;

	// reset values of the configuration registers
	localparam logic [WEIGHT_W-1:0] RST_SMOOTHING_K  = 16'd2149;
	localparam logic [SCALE_W-1:0]  RST_VOLT_SCALE   = 20'd159890;
	localparam logic [SCALE_W-1:0]  RST_AMP_SCALE    = 20'd15027;
	localparam logic [MEAS_W-1:0]   RST_LOW_CUTOFF   = 16'd6000;
	localparam logic [MEAS_W-1:0]   RST_HIGH_CUTOFF  = 16'd8460;
	localparam logic [MEAS_W-1:0]   RST_CURR_FLOOR   = 16'd30;
	localparam logic [MEAS_W-1:0]   RST_HOLD_SECONDS = 16'd30;

endpackage
`default_nettype wire

@@ rtl/core/battery_cutoff_monitor.sv @@
// filtered battery voltage and current monitor with end-of-run cutoff
// a sample word makes six passes through the one shared multiplier (two filter
// updates, four scalings), then a finish step; a start word only has the finish step
// no word is taken until the finish step is done; its result shows up the cycle after
// the finish step waits while a previous result is still held on the output
// arst_n clears the sequencer, the averages, the seeded flag and loads discharge mode
`default_nettype none
module battery_cutoff_monitor import bcm_pkg::*; #(
	parameter int SAMPLE_BITS = 12,
	parameter int FRAC_BITS = 16,
	localparam int IN_DATA_W = ((2 * SAMPLE_BITS + 32 + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// input words
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// voltage_code, current_code, elapsed_seconds
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// command
	input  wire logic                  s_tuser,
	// result words
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// filtered_mv, filtered_ma, raw_mv, raw_ma, source_on, run_mode
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// cutoff_now
	output logic                       m_tlast
);

	localparam int AVG_W = SAMPLE_BITS + FRAC_BITS;
	localparam int OPA_W = AVG_W + 1;
	localparam int OPB_W = SCALE_W + 1;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int SCALE_SHIFT = FRAC_BITS + 16;
	localparam int PAD_W = OUT_DATA_W - 4 * MEAS_W - 3;

	// configuration registers
	logic [WEIGHT_W-1:0] smoothing_k_q;
	logic [SCALE_W-1:0]  volt_scale_q;
	logic [SCALE_W-1:0]  amp_scale_q;
	logic [MEAS_W-1:0]   low_cutoff_q;
	logic [MEAS_W-1:0]   high_cutoff_q;
	logic [MEAS_W-1:0]   curr_floor_q;
	logic [MEAS_W-1:0]   hold_seconds_q;
	logic [1:0]          start_mode_q;

	// captured input word
	logic                   cmd_q;
	logic [SAMPLE_BITS-1:0] vcode_q;
	logic [SAMPLE_BITS-1:0] acode_q;
	logic [31:0]            elapsed_q;

	// state
	seq_state_t         state_q, state_d;
	logic [AVG_W-1:0]   avg_v_q;
	logic [AVG_W-1:0]   avg_a_q;
	logic               seeded_q;
	logic [1:0]         mode_q;
	logic [PROD_W-1:0]  prod_q;
	logic [MEAS_W-1:0]  fmv_q;
	logic [MEAS_W-1:0]  fma_q;
	logic [MEAS_W-1:0]  rmv_q;

	// output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_last_q;

	// control from the output decode
	logic                    in_fire;
	logic                    fin_go;
	logic signed [OPA_W-1:0] op_a;
	logic signed [OPB_W-1:0] op_b;

	// derived values
	logic [AVG_W-1:0]         vx;
	logic [AVG_W-1:0]         ax;
	logic signed [PROD_W-1:0] mul_out;
	logic signed [PROD_W-1:0] rnd_sum;
	logic signed [PROD_W-1:0] rnd_shift;
	logic [AVG_W:0]           ema_new;
	logic [PROD_W-1:0]        scaled;
	logic [MEAS_W-1:0]        sat_val;
	logic [1:0]               start_load;
	logic                     cut_hit;

	assign vx = {vcode_q, {FRAC_BITS{1'b0}}};
	assign ax = {acode_q, {FRAC_BITS{1'b0}}};
	assign in_fire = s_tvalid & s_tready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothing_k_q  <= RST_SMOOTHING_K;
			volt_scale_q   <= RST_VOLT_SCALE;
			amp_scale_q    <= RST_AMP_SCALE;
			low_cutoff_q   <= RST_LOW_CUTOFF;
			high_cutoff_q  <= RST_HIGH_CUTOFF;
			curr_floor_q   <= RST_CURR_FLOOR;
			hold_seconds_q <= RST_HOLD_SECONDS;
			start_mode_q   <= MODE_DISCHARGE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SMOOTHING_K:  smoothing_k_q  <= cfg_data[WEIGHT_W-1:0];
				REG_VOLT_SCALE:   volt_scale_q   <= cfg_data[SCALE_W-1:0];
				REG_AMP_SCALE:    amp_scale_q    <= cfg_data[SCALE_W-1:0];
				REG_LOW_CUTOFF:   low_cutoff_q   <= cfg_data[MEAS_W-1:0];
				REG_HIGH_CUTOFF:  high_cutoff_q  <= cfg_data[MEAS_W-1:0];
				REG_CURR_FLOOR:   curr_floor_q   <= cfg_data[MEAS_W-1:0];
				REG_HOLD_SECONDS: hold_seconds_q <= cfg_data[MEAS_W-1:0];
				REG_START_MODE:   start_mode_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = (s_tuser == CMD_START) ? ST_FINISH : ST_EMA_V;
				end
			end
			ST_EMA_V:  state_d = ST_EMA_A;
			ST_EMA_A:  state_d = ST_FILT_V;
			ST_FILT_V: state_d = ST_FILT_A;
			ST_FILT_A: state_d = ST_RAW_V;
			ST_RAW_V:  state_d = ST_RAW_A;
			ST_RAW_A:  state_d = ST_FINISH;
			ST_FINISH: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs: handshake and multiplier operand select
	always_comb begin
		s_tready = 1'b0;
		fin_go = 1'b0;
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_EMA_V: begin
				op_a = $signed({1'b0, vx}) - $signed({1'b0, avg_v_q});
				op_b = $signed(OPB_W'(smoothing_k_q));
			end
			ST_EMA_A: begin
				op_a = $signed({1'b0, ax}) - $signed({1'b0, avg_a_q});
				op_b = $signed(OPB_W'(smoothing_k_q));
			end
			ST_FILT_V: begin
				op_a = $signed({1'b0, avg_v_q});
				op_b = $signed({1'b0, volt_scale_q});
			end
			ST_FILT_A: begin
				op_a = $signed({1'b0, avg_a_q});
				op_b = $signed({1'b0, amp_scale_q});
			end
			ST_RAW_V: begin
				op_a = $signed({1'b0, vx});
				op_b = $signed({1'b0, volt_scale_q});
			end
			ST_RAW_A: begin
				op_a = $signed({1'b0, ax});
				op_b = $signed({1'b0, amp_scale_q});
			end
			ST_FINISH: fin_go = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	// shared signed multiplier at full product width
	assign mul_out = op_a * op_b;

	// rounded filter step: avg + ((x - avg) * k + half) >>> 16
	assign rnd_sum = $signed(prod_q) + $signed(PROD_W'(1 << (ROUND_SHIFT - 1)));
	assign rnd_shift = rnd_sum >>> ROUND_SHIFT;

	always_comb begin
		ema_new = '0;
		case (state_q)
			ST_EMA_A:  ema_new = {1'b0, avg_v_q} + rnd_shift[AVG_W:0];
			ST_FILT_V: ema_new = {1'b0, avg_a_q} + rnd_shift[AVG_W:0];
			default: ;
		endcase
	end

	// scaled product, saturated to the measurement range
	assign scaled = prod_q >> SCALE_SHIFT;
	assign sat_val = (scaled > PROD_W'(MEAS_MAX)) ? MEAS_MAX : scaled[MEAS_W-1:0];

	// cutoff test and start mode decode
	assign start_load = (start_mode_q == MODE_INVALID) ? MODE_IDLE : start_mode_q;
	assign cut_hit = (mode_q != MODE_IDLE) && (elapsed_q >= 32'(hold_seconds_q)) &&
		(((mode_q == MODE_DISCHARGE) && (fmv_q < low_cutoff_q)) ||
		 ((mode_q == MODE_CHARGE) && (fmv_q > high_cutoff_q)));

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			avg_v_q <= '0;
			avg_a_q <= '0;
			seeded_q <= 1'b0;
			mode_q <= MODE_DISCHARGE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMA_A) begin
				avg_v_q <= seeded_q ? ema_new[AVG_W-1:0] : vx;
			end
			if (state_q == ST_FILT_V) begin
				avg_a_q <= seeded_q ? ema_new[AVG_W-1:0] : ax;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
				if (cmd_q == CMD_START) begin
					mode_q <= start_load;
					seeded_q <= 1'b0;
				end else begin
					seeded_q <= 1'b1;
					if (cut_hit) begin
						mode_q <= MODE_IDLE;
					end
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: captured word, shared multiplier, scaled fields, result word
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= s_tuser;
			vcode_q <= s_tdata[SAMPLE_BITS-1:0];
			acode_q <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
			elapsed_q <= s_tdata[2*SAMPLE_BITS+31:2*SAMPLE_BITS];
		end
		// product of the last pass is held while the finish step waits
		if (state_q != ST_FINISH) begin
			prod_q <= mul_out;
		end
		case (state_q)
			ST_FILT_A: fmv_q <= sat_val;
			ST_RAW_V:  fma_q <= (sat_val < curr_floor_q) ? '0 : sat_val;
			ST_RAW_A:  rmv_q <= sat_val;
			default: ;
		endcase
		if (fin_go) begin
			if (cmd_q == CMD_START) begin
				out_data_q <= {{PAD_W{1'b0}}, start_load, (start_load != MODE_IDLE),
					{(4 * MEAS_W){1'b0}}};
				out_last_q <= 1'b0;
			end else begin
				out_data_q <= {{PAD_W{1'b0}}, (cut_hit ? MODE_IDLE : mode_q),
					(!cut_hit && (mode_q != MODE_IDLE)), sat_val, rmv_q, fma_q, fmv_q};
				out_last_q <= cut_hit;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tlast = out_last_q;

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the battery cutoff monitor
`timescale 1ns / 1ps
module testbench;
	import bcm_pkg::*;

	localparam int IN_W          = ((2 * 12 + 32 + 7) / 8) * 8;
	localparam int RANDOM_WORDS  = 750;
	localparam int SETTLE_CYCLES = 16;
	localparam int QUIET_LIMIT   = 2000;

	// one input word as the block sees it
	typedef struct packed {
		logic        command;
		logic [11:0] vcode;
		logic [11:0] acode;
		logic [31:0] elapsed;
	} sample_t;

	// one result word, fields in output order
	typedef struct packed {
		logic [15:0] filtered_mv;
		logic [15:0] filtered_ma;
		logic [15:0] raw_mv;
		logic [15:0] raw_ma;
		logic        source_on;
		logic [1:0]  run_mode;
		logic        cutoff_now;
	} reading_t;

	// local copy of the register file
	typedef struct {
		logic [15:0] weight;
		logic [19:0] volt_scale;
		logic [19:0] amp_scale;
		logic [15:0] low_mv;
		logic [15:0] high_mv;
		logic [15:0] floor_ma;
		logic [15:0] hold_s;
		logic [1:0]  start_mode;
	} reg_copy_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	sample_t     pending_words[$];
	reading_t    expected_readings[$];
	sample_t     word_on_bus;
	reg_copy_t   cfg_copy;
	logic [27:0] avg_v_q;
	logic [27:0] avg_a_q;
	logic        seeded_q;
	logic [1:0]  mode_q;

	bit          burst_mode = 1'b0;
	int unsigned send_gap = 0;
	int unsigned recv_stall = 0;
	int unsigned quiet_cycles = 0;
	int unsigned words_queued = 0;
	int unsigned words_accepted = 0;
	int unsigned results_checked = 0;
	int unsigned cutoffs_seen = 0;
	int unsigned setups_run = 0;
	int unsigned error_count = 0;

	battery_cutoff_monitor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #4 clk = ~clk;

	// ema update, rounded to nearest with halves up
	function automatic logic [27:0] ema_step(logic [27:0] avg, logic [11:0] code);
		logic [63:0] acc;
		acc = (64'(code) << 16) * 64'(cfg_copy.weight)
			+ 64'(avg) * (64'd65536 - 64'(cfg_copy.weight)) + 64'd32768;
		return 28'(acc >> 16);
	endfunction

	// filtered average to units, truncated and saturated
	function automatic logic [15:0] scale_avg(logic [27:0] avg, logic [19:0] scale);
		logic [63:0] prod;
		prod = (64'(avg) * 64'(scale)) >> 32;
		return (prod > 64'(MEAS_MAX)) ? MEAS_MAX : prod[15:0];
	endfunction

	// raw code to units, truncated and saturated
	function automatic logic [15:0] scale_raw(logic [11:0] code, logic [19:0] scale);
		logic [63:0] prod;
		prod = (64'(code) * 64'(scale)) >> 16;
		return (prod > 64'(MEAS_MAX)) ? MEAS_MAX : prod[15:0];
	endfunction

	// expected reading for one accepted word, advances the local state
	function automatic reading_t predict_reading(sample_t smp);
		reading_t r;
		r = '0;
		if (smp.command == CMD_START) begin
			mode_q   = (cfg_copy.start_mode == MODE_INVALID) ? MODE_IDLE : cfg_copy.start_mode;
			seeded_q = 1'b0;
		end else begin
			if (seeded_q) begin
				avg_v_q = ema_step(avg_v_q, smp.vcode);
				avg_a_q = ema_step(avg_a_q, smp.acode);
			end else begin
				avg_v_q  = {smp.vcode, 16'h0000};
				avg_a_q  = {smp.acode, 16'h0000};
				seeded_q = 1'b1;
			end
			r.filtered_mv = scale_avg(avg_v_q, cfg_copy.volt_scale);
			r.filtered_ma = scale_avg(avg_a_q, cfg_copy.amp_scale);
			if (r.filtered_ma < cfg_copy.floor_ma)
				r.filtered_ma = '0;
			r.raw_mv = scale_raw(smp.vcode, cfg_copy.volt_scale);
			r.raw_ma = scale_raw(smp.acode, cfg_copy.amp_scale);
			// end of run once the hold time has passed
			if (mode_q != MODE_IDLE && smp.elapsed >= 32'(cfg_copy.hold_s)) begin
				if ((mode_q == MODE_DISCHARGE && r.filtered_mv < cfg_copy.low_mv) ||
					(mode_q == MODE_CHARGE && r.filtered_mv > cfg_copy.high_mv)) begin
					mode_q       = MODE_IDLE;
					r.cutoff_now = 1'b1;
				end
			end
		end
		r.source_on = (mode_q != MODE_IDLE);
		r.run_mode  = mode_q;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t ns: %s", $realtime, what);
		error_count++;
	endtask

	task automatic queue_word(logic cmd, int unsigned v, int unsigned a, logic [31:0] secs);
		sample_t smp;
		smp.command = cmd;
		smp.vcode   = 12'(v);
		smp.acode   = 12'(a);
		smp.elapsed = secs;
		pending_words.push_back(smp);
		words_queued++;
	endtask

	// register write, mirrored locally with the unused bits dropped
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_SMOOTHING_K:  cfg_copy.weight     = value[15:0];
			REG_VOLT_SCALE:   cfg_copy.volt_scale = value;
			REG_AMP_SCALE:    cfg_copy.amp_scale  = value;
			REG_LOW_CUTOFF:   cfg_copy.low_mv     = value[15:0];
			REG_HIGH_CUTOFF:  cfg_copy.high_mv    = value[15:0];
			REG_CURR_FLOOR:   cfg_copy.floor_ma   = value[15:0];
			REG_HOLD_SECONDS: cfg_copy.hold_s     = value[15:0];
			REG_START_MODE:   cfg_copy.start_mode = value[1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every word is in and every reading is out, then let the block go quiet
	task automatic settle();
		while (words_accepted != words_queued || expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		setups_run++;
	endtask

	function automatic int clamp_code(int v);
		return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
	endfunction

	// 16-bit register value with junk in the unused upper bits
	function automatic logic [19:0] with_junk(int unsigned v);
		return {4'($urandom_range(0, 15)), 16'(v)};
	endfunction

	// start word then a drifting voltage trace toward the cutoff of the loaded mode
	task automatic queue_run(int unsigned length);
		int          v;
		int          a;
		int          dir;
		logic [31:0] secs;
		dir  = (cfg_copy.start_mode == MODE_CHARGE) ? 1 : -1;
		v    = (dir > 0) ? $urandom_range(0, 2500) : $urandom_range(1500, 4095);
		a    = $urandom_range(0, 4095);
		secs = $urandom_range(0, 32'(cfg_copy.hold_s) + 3);
		queue_word(CMD_START, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom());
		repeat (length) begin
			v    = clamp_code(v + dir * int'($urandom_range(0, 120)) + int'($urandom_range(0, 40)) - 20);
			a    = clamp_code(a + int'($urandom_range(0, 200)) - 100);
			secs = secs + $urandom_range(0, 6);
			queue_word(CMD_SAMPLE, v, a, secs);
		end
	endtask

	// words in: hand out queued words with a random gap after each, none in burst mode
	always @(posedge clk) begin : drive_words
		sample_t nxt;
		logic    load;
		nxt  = '0;
		load = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_readings.push_back(predict_reading(word_on_bus));
				words_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (pending_words.size() != 0) begin
					nxt      = pending_words.pop_front();
					load     = 1'b1;
					send_gap = burst_mode ? 0 : $urandom_range(0, 15);
				end
				s_tvalid <= load;
				if (load) begin
					word_on_bus <= nxt;
					s_tuser     <= nxt.command;
					s_tdata     <= {nxt.elapsed, nxt.acode, nxt.vcode};
				end
			end
		end
	end

	// readings out: random back-pressure unless in burst mode, compare against the oldest prediction
	always @(posedge clk) begin : watch_readings
		reading_t got;
		reading_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.filtered_mv = m_tdata[15:0];
				got.filtered_ma = m_tdata[31:16];
				got.raw_mv      = m_tdata[47:32];
				got.raw_ma      = m_tdata[63:48];
				got.source_on   = m_tdata[64];
				got.run_mode    = m_tdata[66:65];
				got.cutoff_now  = m_tlast;
				if (expected_readings.size() == 0) begin
					report_mismatch($sformatf("reading %0d arrived with nothing expected",
						results_checked));
				end else begin
					want = expected_readings.pop_front();
					if (got.filtered_mv !== want.filtered_mv)
						report_mismatch($sformatf("reading %0d filtered_mv %0d, want %0d",
							results_checked, got.filtered_mv, want.filtered_mv));
					if (got.filtered_ma !== want.filtered_ma)
						report_mismatch($sformatf("reading %0d filtered_ma %0d, want %0d",
							results_checked, got.filtered_ma, want.filtered_ma));
					if (got.raw_mv !== want.raw_mv)
						report_mismatch($sformatf("reading %0d raw_mv %0d, want %0d",
							results_checked, got.raw_mv, want.raw_mv));
					if (got.raw_ma !== want.raw_ma)
						report_mismatch($sformatf("reading %0d raw_ma %0d, want %0d",
							results_checked, got.raw_ma, want.raw_ma));
					if (got.source_on !== want.source_on)
						report_mismatch($sformatf("reading %0d source_on %0b, want %0b",
							results_checked, got.source_on, want.source_on));
					if (got.run_mode !== want.run_mode)
						report_mismatch($sformatf("reading %0d run_mode %0d, want %0d",
							results_checked, got.run_mode, want.run_mode));
					if (got.cutoff_now !== want.cutoff_now)
						report_mismatch($sformatf("reading %0d cutoff_now %0b, want %0b",
							results_checked, got.cutoff_now, want.cutoff_now));
				end
				results_checked++;
				if (got.cutoff_now === 1'b1)
					cutoffs_seen++;
				recv_stall = burst_mode ? 0 : $urandom_range(0, 15);
			end else if (recv_stall != 0 && m_tvalid) begin
				recv_stall--;
			end
			m_tready <= (recv_stall == 0);
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus
	initial begin
		int unsigned phase_end;
		cfg_copy.weight     = RST_SMOOTHING_K;
		cfg_copy.volt_scale = RST_VOLT_SCALE;
		cfg_copy.amp_scale  = RST_AMP_SCALE;
		cfg_copy.low_mv     = RST_LOW_CUTOFF;
		cfg_copy.high_mv    = RST_HIGH_CUTOFF;
		cfg_copy.floor_ma   = RST_CURR_FLOOR;
		cfg_copy.hold_s     = RST_HOLD_SECONDS;
		cfg_copy.start_mode = MODE_DISCHARGE;
		avg_v_q  = '0;
		avg_a_q  = '0;
		seeded_q = 1'b0;
		mode_q   = MODE_DISCHARGE;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: seed, hold time, discharge cutoff, idle after the cut, floor
		queue_word(CMD_SAMPLE, 0, 0, 32'd0);
		queue_word(CMD_SAMPLE, 4095, 4095, 32'd29);
		queue_word(CMD_SAMPLE, 0, 0, 32'd30);
		queue_word(CMD_SAMPLE, 4095, 4095, 32'hFFFF_FFFF);
		queue_word(CMD_START, 4095, 4095, 32'hFFFF_FFFF);
		queue_word(CMD_SAMPLE, 4095, 10, 32'hFFFF_FFFF);
		settle();

		// charge run with no hold time
		write_register(REG_START_MODE, 20'hABCD2);
		write_register(REG_HOLD_SECONDS, 20'hF0000);
		queue_word(CMD_START, 0, 0, 32'd0);
		queue_word(CMD_SAMPLE, 4095, 2048, 32'd0);
		queue_word(CMD_START, 1234, 567, 32'd0);
		queue_word(CMD_SAMPLE, 2000, 100, 32'd0);
		queue_word(CMD_SAMPLE, 3500, 4000, 32'd5);
		settle();

		// meaningless start mode, zero weight, scale extremes, no floor
		write_register(REG_START_MODE, 20'(MODE_INVALID));
		write_register(REG_SMOOTHING_K, 20'h00000);
		write_register(REG_VOLT_SCALE, 20'hFFFFF);
		write_register(REG_AMP_SCALE, 20'h00000);
		write_register(REG_CURR_FLOOR, 20'h00000);
		queue_word(CMD_START, 0, 0, 32'd0);
		queue_word(CMD_SAMPLE, 4095, 4095, 32'd100);
		queue_word(CMD_SAMPLE, 0, 0, 32'd100);
		queue_word(CMD_SAMPLE, 1, 1, 32'd100);
		settle();

		// idle start, full weight, low cutoff and floor and hold at the top, high cutoff at zero
		write_register(REG_START_MODE, 20'(MODE_IDLE));
		write_register(REG_SMOOTHING_K, 20'h5FFFF);
		write_register(REG_LOW_CUTOFF, 20'h0FFFF);
		write_register(REG_HIGH_CUTOFF, 20'h30000);
		write_register(REG_CURR_FLOOR, 20'hFFFFF);
		write_register(REG_HOLD_SECONDS, 20'h0FFFF);
		write_register(REG_VOLT_SCALE, 20'h00000);
		write_register(REG_AMP_SCALE, 20'hFFFFF);
		queue_word(CMD_START, 0, 0, 32'd0);
		queue_word(CMD_SAMPLE, 4095, 4095, 32'd65535);
		queue_word(CMD_SAMPLE, 0, 0, 32'd0);
		settle();

		// discharge just short of and at the hold time
		write_register(REG_START_MODE, 20'(MODE_DISCHARGE));
		queue_word(CMD_START, 0, 0, 32'd0);
		queue_word(CMD_SAMPLE, 2048, 2048, 32'd65534);
		queue_word(CMD_SAMPLE, 2048, 2048, 32'd65535);
		settle();

		// charge with a zero high cutoff and a tiny scale
		write_register(REG_START_MODE, 20'(MODE_CHARGE));
		write_register(REG_HOLD_SECONDS, 20'h00000);
		write_register(REG_VOLT_SCALE, 20'h00001);
		queue_word(CMD_START, 0, 0, 32'd0);
		queue_word(CMD_SAMPLE, 4095, 4095, 32'd0);
		queue_word(CMD_SAMPLE, 4095, 0, 32'd1);

		// random setups, mostly well-formed runs with some noise
		while (words_queued < RANDOM_WORDS) begin
			settle();
			burst_mode = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 7))
				0: write_register(REG_SMOOTHING_K, with_junk(0));
				1: write_register(REG_SMOOTHING_K, with_junk(16'hFFFF));
				default: write_register(REG_SMOOTHING_K, with_junk($urandom_range(500, 40000)));
			endcase
			case ($urandom_range(0, 9))
				0: write_register(REG_VOLT_SCALE, 20'hFFFFF);
				1: write_register(REG_VOLT_SCALE, 20'h00000);
				default: write_register(REG_VOLT_SCALE, 20'($urandom_range(100000, 250000)));
			endcase
			case ($urandom_range(0, 9))
				0: write_register(REG_AMP_SCALE, 20'hFFFFF);
				1: write_register(REG_AMP_SCALE, 20'h00000);
				default: write_register(REG_AMP_SCALE, 20'($urandom_range(5000, 60000)));
			endcase
			write_register(REG_LOW_CUTOFF, with_junk($urandom_range(2000, 9000)));
			write_register(REG_HIGH_CUTOFF, with_junk($urandom_range(6000, 14000)));
			case ($urandom_range(0, 9))
				0: write_register(REG_CURR_FLOOR, with_junk(0));
				1: write_register(REG_CURR_FLOOR, with_junk(16'hFFFF));
				default: write_register(REG_CURR_FLOOR, with_junk($urandom_range(0, 300)));
			endcase
			if ($urandom_range(0, 9) == 0)
				write_register(REG_HOLD_SECONDS, with_junk(16'hFFFF));
			else
				write_register(REG_HOLD_SECONDS, with_junk($urandom_range(0, 120)));
			case ($urandom_range(0, 5))
				0: write_register(REG_START_MODE, {18'($urandom()), MODE_IDLE});
				1: write_register(REG_START_MODE, {18'($urandom()), MODE_INVALID});
				2, 3: write_register(REG_START_MODE, {18'($urandom()), MODE_DISCHARGE});
				default: write_register(REG_START_MODE, {18'($urandom()), MODE_CHARGE});
			endcase
			phase_end = words_queued + 70;
			while (words_queued < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 6))
						queue_word(($urandom_range(0, 3) == 0) ? CMD_START : CMD_SAMPLE,
							$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom());
				end else begin
					queue_run($urandom_range(3, 40));
				end
			end
		end
		settle();

		$display("%0d words sent, %0d readings checked, %0d cutoffs seen",
			words_accepted, results_checked, cutoffs_seen);
		$display("%0d register setups, %0d mismatches", setups_run, error_count);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
